// ===== hdl/slm_pkg.sv =====
// ----------------------------------------------------------------------------
// slm_pkg
// Shared types and codes for the static linked list engine.
// ----------------------------------------------------------------------------
package slm_pkg;

    localparam int REQ_W  = 2;
    localparam int POS_W  = 7;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;

    typedef logic [REQ_W-1:0]         req_t;
    typedef logic [POS_W-1:0]         pos_t;
    typedef logic signed [VAL_W-1:0]  val_t;
    typedef logic [STAT_W-1:0]        stat_t;

    // request codes
    localparam req_t REQ_INSERT = 2'd0;
    localparam req_t REQ_DELETE = 2'd1;
    localparam req_t REQ_READ   = 2'd2;

    // status codes
    localparam stat_t STAT_OK    = 2'd0;
    localparam stat_t STAT_RANGE = 2'd1;
    localparam stat_t STAT_FULL  = 2'd2;

    // write enables from the sequencer to the table storage
    typedef struct packed {
        logic link_we;
        logic pay_we;
    } slm_wr_t;

endpackage

// ===== hdl/slm_req_if.sv =====
// ----------------------------------------------------------------------------
// slm_req_if
// Request channel: operation, list position and element value.
// ----------------------------------------------------------------------------
interface slm_req_if;

    logic           valid;
    logic           ready;
    slm_pkg::req_t  req_type;
    slm_pkg::pos_t  position;
    slm_pkg::val_t  value;

    modport source (output valid, output req_type, output position, output value,
                    input ready);
    modport sink   (input valid, input req_type, input position, input value,
                    output ready);

endinterface

// ===== hdl/slm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// slm_rsp_if
// Response channel: status and read element.
// ----------------------------------------------------------------------------
interface slm_rsp_if;

    logic           valid;
    logic           ready;
    slm_pkg::stat_t status;
    slm_pkg::val_t  read_value;

    modport source (output valid, output status, output read_value, input ready);
    modport sink   (input valid, input status, input read_value, output ready);

endinterface

// ===== hdl/slm_store.sv =====
// ----------------------------------------------------------------------------
// slm_store
// Link table and payload table, one write and one registered read port each.
// ----------------------------------------------------------------------------
module slm_store #(
    parameter int SLOTS = 128
) (
    input  logic                  clk,
    input  slm_pkg::slm_wr_t      wr,
    input  logic [$clog2(SLOTS)-1:0] link_raddr,
    input  logic [$clog2(SLOTS)-1:0] link_waddr,
    input  logic [$clog2(SLOTS)-1:0] link_wdata,
    output logic [$clog2(SLOTS)-1:0] link_rdata,
    input  logic [$clog2(SLOTS)-1:0] pay_raddr,
    input  logic [$clog2(SLOTS)-1:0] pay_waddr,
    input  slm_pkg::val_t         pay_wdata,
    output slm_pkg::val_t         pay_rdata
);

    localparam int SW = $clog2(SLOTS);

    logic [SW-1:0] link_mem [SLOTS];
    slm_pkg::val_t pay_mem  [SLOTS];

    // link table
    always_ff @(posedge clk)
    begin
        if (wr.link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_rdata <= link_mem[link_raddr];
    end

    // payload table
    always_ff @(posedge clk)
    begin
        if (wr.pay_we)
        begin
            pay_mem[pay_waddr] <= pay_wdata;
        end
        pay_rdata <= pay_mem[pay_raddr];
    end

endmodule

// ===== hdl/slm_ctrl.sv =====
// ----------------------------------------------------------------------------
// slm_ctrl
// Request sequencer: link table init sweep, range checks, link walk and
// the read-modify-write steps of insert and delete.
// ----------------------------------------------------------------------------
module slm_ctrl #(
    parameter int SLOTS = 128
) (
    input  logic                     clk,
    input  logic                     rst_n,
    slm_req_if.sink                  req,
    output logic                     res_valid,
    input  logic                     res_ready,
    output slm_pkg::stat_t           res_status,
    output slm_pkg::val_t            res_value,
    output slm_pkg::slm_wr_t         wr,
    output logic [$clog2(SLOTS)-1:0] link_raddr,
    output logic [$clog2(SLOTS)-1:0] link_waddr,
    output logic [$clog2(SLOTS)-1:0] link_wdata,
    input  logic [$clog2(SLOTS)-1:0] link_rdata,
    output logic [$clog2(SLOTS)-1:0] pay_raddr,
    output logic [$clog2(SLOTS)-1:0] pay_waddr,
    output slm_pkg::val_t            pay_wdata,
    input  slm_pkg::val_t            pay_rdata
);

    localparam int SW = $clog2(SLOTS);
    localparam int XW = (SW > slm_pkg::POS_W) ? SW : slm_pkg::POS_W;

    localparam logic [SW-1:0] HEAD_SLOT = SW'(SLOTS - 1);
    localparam logic [SW-1:0] FREE_SLOT = '0;
    localparam logic [SW-1:0] CAPACITY  = SW'(SLOTS - 2);

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_FREE_B = 4'd2;
    localparam logic [3:0] S_FREE_C = 4'd3;
    localparam logic [3:0] S_WALK   = 4'd4;
    localparam logic [3:0] S_INS_B  = 4'd5;
    localparam logic [3:0] S_INS_C  = 4'd6;
    localparam logic [3:0] S_DEL_B  = 4'd7;
    localparam logic [3:0] S_DEL_C  = 4'd8;
    localparam logic [3:0] S_DEL_D  = 4'd9;
    localparam logic [3:0] S_DEL_E  = 4'd10;
    localparam logic [3:0] S_RD_B   = 4'd11;
    localparam logic [3:0] S_DONE   = 4'd12;

    logic [3:0]     state_reg, state_next;
    logic [SW-1:0]  cur_reg, cur_next;       // walk cursor, init counter
    logic [SW-1:0]  count_reg, count_next;
    logic [SW-1:0]  steps_reg, steps_next;
    logic [SW-1:0]  node_reg, node_next;     // new or removed node
    logic [SW-1:0]  aux_reg, aux_next;       // successor to relink
    logic [SW-1:0]  free_reg, free_next;     // free chain head to store
    slm_pkg::req_t  op_reg, op_next;
    slm_pkg::val_t  val_reg, val_next;
    slm_pkg::stat_t stat_reg, stat_next;
    slm_pkg::val_t  rval_reg, rval_next;

    logic [XW-1:0]  pos_x;
    logic [XW-1:0]  cnt_x;

    assign pos_x = XW'(req.position);
    assign cnt_x = XW'(count_reg);

    assign req.ready  = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_DONE);
    assign res_status = stat_reg;
    assign res_value  = rval_reg;
    assign pay_waddr  = node_reg;
    assign pay_wdata  = val_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        count_next = count_reg;
        steps_next = steps_reg;
        node_next  = node_reg;
        aux_next   = aux_reg;
        free_next  = free_reg;
        op_next    = op_reg;
        val_next   = val_reg;
        stat_next  = stat_reg;
        rval_next  = rval_reg;
        wr         = '0;
        link_raddr = cur_reg;
        link_waddr = cur_reg;
        link_wdata = '0;
        pay_raddr  = cur_reg;

        case (state_reg)
            S_INIT:
            begin
                // entry i links to i+1, the last entry closes the free chain
                wr.link_we = 1'b1;
                link_wdata = (cur_reg == HEAD_SLOT) ? FREE_SLOT : SW'(cur_reg + 1'b1);
                cur_next   = SW'(cur_reg + 1'b1);
                if (cur_reg == HEAD_SLOT)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.req_type;
                    val_next   = req.value;
                    stat_next  = slm_pkg::STAT_OK;
                    rval_next  = '0;
                    cur_next   = HEAD_SLOT;
                    steps_next = SW'(req.position);
                    case (req.req_type)
                        slm_pkg::REQ_INSERT:
                        begin
                            if (pos_x > cnt_x)
                            begin
                                stat_next  = slm_pkg::STAT_RANGE;
                                state_next = S_DONE;
                            end
                            else if (count_reg == CAPACITY)
                            begin
                                stat_next  = slm_pkg::STAT_FULL;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                link_raddr = FREE_SLOT;
                                state_next = S_FREE_B;
                            end
                        end
                        slm_pkg::REQ_DELETE:
                        begin
                            if (pos_x < cnt_x)
                            begin
                                link_raddr = HEAD_SLOT;
                                state_next = S_WALK;
                            end
                            else
                            begin
                                stat_next  = slm_pkg::STAT_RANGE;
                                state_next = S_DONE;
                            end
                        end
                        slm_pkg::REQ_READ:
                        begin
                            if (pos_x < cnt_x)
                            begin
                                steps_next = SW'(pos_x + XW'(1));
                                link_raddr = HEAD_SLOT;
                                state_next = S_WALK;
                            end
                            else
                            begin
                                stat_next  = slm_pkg::STAT_RANGE;
                                state_next = S_DONE;
                            end
                        end
                        default:
                        begin
                            stat_next  = slm_pkg::STAT_RANGE;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_FREE_B:
            begin
                // free chain head becomes the new node; fetch its link
                node_next  = link_rdata;
                link_raddr = link_rdata;
                state_next = S_FREE_C;
            end
            S_FREE_C:
            begin
                free_next  = link_rdata;
                cur_next   = HEAD_SLOT;
                link_raddr = HEAD_SLOT;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                // read data holds the link of the cursor slot
                if (steps_reg != '0)
                begin
                    cur_next   = link_rdata;
                    steps_next = SW'(steps_reg - 1'b1);
                    link_raddr = link_rdata;
                end
                else
                begin
                    case (op_reg)
                        slm_pkg::REQ_INSERT:
                        begin
                            wr.link_we = 1'b1;
                            wr.pay_we  = 1'b1;
                            link_waddr = cur_reg;
                            link_wdata = node_reg;
                            aux_next   = link_rdata;
                            state_next = S_INS_B;
                        end
                        slm_pkg::REQ_DELETE:
                        begin
                            node_next  = link_rdata;
                            link_raddr = link_rdata;
                            state_next = S_DEL_B;
                        end
                        default:
                        begin
                            pay_raddr  = cur_reg;
                            state_next = S_RD_B;
                        end
                    endcase
                end
            end
            S_INS_B:
            begin
                wr.link_we = 1'b1;
                link_waddr = node_reg;
                link_wdata = aux_reg;
                state_next = S_INS_C;
            end
            S_INS_C:
            begin
                wr.link_we = 1'b1;
                link_waddr = FREE_SLOT;
                link_wdata = free_reg;
                count_next = SW'(count_reg + 1'b1);
                state_next = S_DONE;
            end
            S_DEL_B:
            begin
                // successor of the removed node; then fetch free chain head
                aux_next   = link_rdata;
                link_raddr = FREE_SLOT;
                state_next = S_DEL_C;
            end
            S_DEL_C:
            begin
                free_next  = link_rdata;
                wr.link_we = 1'b1;
                link_waddr = cur_reg;
                link_wdata = aux_reg;
                state_next = S_DEL_D;
            end
            S_DEL_D:
            begin
                wr.link_we = 1'b1;
                link_waddr = node_reg;
                link_wdata = free_reg;
                state_next = S_DEL_E;
            end
            S_DEL_E:
            begin
                wr.link_we = 1'b1;
                link_waddr = FREE_SLOT;
                link_wdata = node_reg;
                count_next = SW'(count_reg - 1'b1);
                state_next = S_DONE;
            end
            S_RD_B:
            begin
                rval_next  = pay_rdata;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            cur_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            count_reg <= count_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        steps_reg <= steps_next;
        node_reg  <= node_next;
        aux_reg   <= aux_next;
        free_reg  <= free_next;
        op_reg    <= op_next;
        val_reg   <= val_next;
        stat_reg  <= stat_next;
        rval_reg  <= rval_next;
    end

endmodule

// ===== hdl/static_linked_list_engine.sv =====
// After reset the block sweeps the link table once, one entry per cycle, and
// ready stays low until the sweep ends. Each item is then handled alone: a
// request with a bad position, an unknown code or a full list goes straight
// to the result; read, insert and delete at position p first walk from the
// list head through the link table, one link per cycle through its single
// registered read port. The result sits in an output register, so the next
// item is taken while it waits.
// ----------------------------------------------------------------------------
// static_linked_list_engine
// Table-backed linked list with a free chain: insert, delete and read at a
// list position.
// ----------------------------------------------------------------------------
module static_linked_list_engine #(
    parameter int SLOTS = 128
) (
    input  logic      clk,
    input  logic      rst_n,
    slm_req_if.sink   req,
    slm_rsp_if.source rsp
);

    localparam int SW = $clog2(SLOTS);

    slm_pkg::slm_wr_t wr;
    logic [SW-1:0]    link_raddr;
    logic [SW-1:0]    link_waddr;
    logic [SW-1:0]    link_wdata;
    logic [SW-1:0]    link_rdata;
    logic [SW-1:0]    pay_raddr;
    logic [SW-1:0]    pay_waddr;
    slm_pkg::val_t    pay_wdata;
    slm_pkg::val_t    pay_rdata;

    logic             res_valid;
    logic             res_ready;
    slm_pkg::stat_t   res_status;
    slm_pkg::val_t    res_value;

    logic             out_valid_reg;
    slm_pkg::stat_t   out_stat_reg;
    slm_pkg::val_t    out_val_reg;

    slm_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_status (res_status),
        .res_value  (res_value),
        .wr         (wr),
        .link_raddr (link_raddr),
        .link_waddr (link_waddr),
        .link_wdata (link_wdata),
        .link_rdata (link_rdata),
        .pay_raddr  (pay_raddr),
        .pay_waddr  (pay_waddr),
        .pay_wdata  (pay_wdata),
        .pay_rdata  (pay_rdata)
    );

    slm_store #(
        .SLOTS (SLOTS)
    ) u_store (
        .clk        (clk),
        .wr         (wr),
        .link_raddr (link_raddr),
        .link_waddr (link_waddr),
        .link_wdata (link_wdata),
        .link_rdata (link_rdata),
        .pay_raddr  (pay_raddr),
        .pay_waddr  (pay_waddr),
        .pay_wdata  (pay_wdata),
        .pay_rdata  (pay_rdata)
    );

    // output register
    assign res_ready      = !out_valid_reg || rsp.ready;
    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_stat_reg;
    assign rsp.read_value = out_val_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_stat_reg <= res_status;
            out_val_reg  <= res_value;
        end
    end

endmodule

// ===== hdl/slm_checker.sv =====
// ----------------------------------------------------------------------------
// slm_checker
// Port-level checks for the static linked list engine, bound to the top.
// ----------------------------------------------------------------------------
module slm_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input slm_pkg::stat_t rsp_status,
    input slm_pkg::val_t  rsp_read_value
);

    logic [1:0] pend_reg;
    logic       req_fire;
    logic       rsp_fire;

    assign req_fire = req_valid && req_ready;
    assign rsp_fire = rsp_valid && rsp_ready;

    // items taken but not yet answered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else if (req_fire && !rsp_fire)
        begin
            pend_reg <= 2'(pend_reg + 1'b1);
        end
        else if (!req_fire && rsp_fire)
        begin
            pend_reg <= 2'(pend_reg - 1'b1);
        end
    end

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                    && $stable(rsp_read_value))
        else $error("result changed while stalled");

    // no answer without a request, and at most one item in work plus one waiting
    a_pending: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 2'd2 && !(rsp_valid && pend_reg == 2'd0))
        else $error("result count does not match request count");

    // only the defined status codes appear
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_status == slm_pkg::STAT_OK
                       || rsp_status == slm_pkg::STAT_RANGE
                       || rsp_status == slm_pkg::STAT_FULL))
        else $error("undefined status code");

    // a failed request returns a zero element
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != slm_pkg::STAT_OK |-> rsp_read_value == '0)
        else $error("nonzero element on failed request");

endmodule

bind static_linked_list_engine slm_checker u_slm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status),
    .rsp_read_value (rsp.read_value)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the static linked list engine. A queue-fed driver
// sends insert, delete and read requests. A monitor predicts each response
// from a shadow copy of the link table and compares it with what comes out.
// A directed opening is followed by randomized fill, drain and mixed
// sequences under several idling profiles.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS       = 128;
    localparam int HEAD_SLOT   = SLOTS - 1;
    localparam int CAPACITY    = SLOTS - 2;
    localparam int ITEMS_PHASE = 330;
    localparam int LONG_HOLD   = 400;
    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYCLES = 150;

    typedef struct packed {
        slm_pkg::req_t req_type;
        slm_pkg::pos_t position;
        slm_pkg::val_t value;
    } list_req_t;

    typedef struct packed {
        slm_pkg::stat_t status;
        slm_pkg::val_t  read_value;
    } list_rsp_t;

    typedef enum int {SEG_FILL, SEG_DRAIN, SEG_MIX} seg_kind_t;

    logic clk;
    logic rst_n;

    slm_req_if req_ch ();
    slm_rsp_if rsp_ch ();

    static_linked_list_engine #(.SLOTS(SLOTS)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // shadow list: element words, links and element count
    slm_pkg::val_t slot_value [SLOTS];
    slm_pkg::pos_t slot_link  [SLOTS];
    int            elem_count;

    list_req_t pending_reqs[$];
    list_rsp_t owed_responses[$];
    list_req_t next_req;

    int gen_count;          // list length as seen by the request generator
    int send_idle_pct;
    int recv_stall_pct;
    int fail_count;
    int results_seen;
    int hold_left;
    bit long_hold_done;
    int quiet_cycles;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Shadow list model
    // ------------------------------------------------------------------------
    task automatic clear_list();
        for (int k = 0; k < SLOTS; k++)
        begin
            slot_value[k] = '0;
            slot_link[k]  = slm_pkg::pos_t'(k + 1);
        end
        slot_link[SLOTS-1] = '0;
        elem_count = 0;
    endtask

    // follow links from the list head
    function automatic int slot_at(int steps);
        int at;
        at = HEAD_SLOT;
        for (int k = 0; k < steps; k++)
            at = slot_link[at];
        return at;
    endfunction

    function automatic list_rsp_t apply_request(list_req_t rq);
        list_rsp_t r;
        int pos;
        int node;
        int pred;
        r.status     = slm_pkg::STAT_RANGE;
        r.read_value = '0;
        pos = int'(rq.position);
        case (rq.req_type)
            slm_pkg::REQ_INSERT:
            begin
                // range check wins over the full check
                if (pos > elem_count)
                    r.status = slm_pkg::STAT_RANGE;
                else if (elem_count >= CAPACITY)
                    r.status = slm_pkg::STAT_FULL;
                else
                begin
                    node = slot_link[0];
                    pred = slot_at(pos);
                    slot_link[0]    = slot_link[node];
                    slot_value[node] = rq.value;
                    slot_link[node] = slot_link[pred];
                    slot_link[pred] = slm_pkg::pos_t'(node);
                    elem_count++;
                    r.status = slm_pkg::STAT_OK;
                end
            end
            slm_pkg::REQ_DELETE:
            begin
                if (pos < elem_count)
                begin
                    pred = slot_at(pos);
                    node = slot_link[pred];
                    slot_link[pred] = slot_link[node];
                    slot_link[node] = slot_link[0];
                    slot_link[0]    = slm_pkg::pos_t'(node);
                    elem_count--;
                    r.status = slm_pkg::STAT_OK;
                end
            end
            slm_pkg::REQ_READ:
            begin
                if (pos < elem_count)
                begin
                    node = slot_at(pos + 1);
                    r.read_value = slot_value[node];
                    r.status     = slm_pkg::STAT_OK;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Request generation
    // ------------------------------------------------------------------------
    task automatic queue_request(slm_pkg::req_t op, slm_pkg::pos_t p, slm_pkg::val_t v);
        pending_reqs.push_back('{req_type: op, position: p, value: v});
        if (op == slm_pkg::REQ_INSERT && int'(p) <= gen_count && gen_count < CAPACITY)
            gen_count++;
        else if (op == slm_pkg::REQ_DELETE && int'(p) < gen_count)
            gen_count--;
    endtask

    // position inside the list, leaning toward both ends
    function automatic slm_pkg::pos_t pick_position(int top);
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        if (r < 20)
            return slm_pkg::pos_t'(top);
        return slm_pkg::pos_t'($urandom_range(top, 0));
    endfunction

    task automatic queue_segment(seg_kind_t kind, int len);
        int r;
        int ins_pct;
        int del_pct;
        slm_pkg::req_t op;
        slm_pkg::pos_t p;
        case (kind)
            SEG_FILL:  begin ins_pct = 85; del_pct = 5;  end
            SEG_DRAIN: begin ins_pct = 10; del_pct = 70; end
            default:   begin ins_pct = 34; del_pct = 33; end
        endcase
        for (int i = 0; i < len; i++)
        begin
            r = $urandom_range(99);
            if ($urandom_range(99) < 8)
            begin
                // noise: any code, any position
                op = slm_pkg::req_t'($urandom_range(3));
                p  = slm_pkg::pos_t'($urandom_range(127));
            end
            else if (r < ins_pct)
            begin
                op = slm_pkg::REQ_INSERT;
                p  = pick_position(gen_count);
            end
            else
            begin
                op = (r < ins_pct + del_pct) ? slm_pkg::REQ_DELETE : slm_pkg::REQ_READ;
                p  = (gen_count == 0) ? slm_pkg::pos_t'($urandom_range(127))
                                      : pick_position(gen_count - 1);
            end
            queue_request(op, p, slm_pkg::val_t'($urandom));
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || owed_responses.size() != 0 || req_ch.valid)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        int queued;
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = slm_pkg::REQ_INSERT;
        req_ch.position = '0;
        req_ch.value    = '0;
        rsp_ch.ready    = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        gen_count       = 0;
        fail_count      = 0;
        clear_list();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty list, bad positions, unknown code
        queue_request(slm_pkg::REQ_READ,   7'd0,   32'sd5);
        queue_request(slm_pkg::REQ_DELETE, 7'd0,   32'sd5);
        queue_request(slm_pkg::REQ_INSERT, 7'd1,   32'sd9);
        queue_request(slm_pkg::REQ_INSERT, 7'd127, 32'sd9);
        queue_request(slm_pkg::req_t'(3),  7'd0,   32'sd1);
        // extremes of the element, head, tail and middle inserts
        queue_request(slm_pkg::REQ_INSERT, 7'd0,   32'sh7fffffff);
        queue_request(slm_pkg::REQ_INSERT, 7'd1,   32'sh80000000);
        queue_request(slm_pkg::REQ_INSERT, 7'd0,   -32'sd1);
        queue_request(slm_pkg::REQ_INSERT, 7'd1,   32'sd0);
        for (int k = 0; k < 4; k++)
            queue_request(slm_pkg::REQ_READ, slm_pkg::pos_t'(k), 32'sd0);
        queue_request(slm_pkg::REQ_READ,   7'd4,   32'sd0);
        queue_request(slm_pkg::REQ_DELETE, 7'd4,   32'sd0);
        // delete tail, then head, then middle
        queue_request(slm_pkg::REQ_DELETE, 7'd3,   32'sd0);
        queue_request(slm_pkg::REQ_DELETE, 7'd0,   32'sd0);
        queue_request(slm_pkg::REQ_READ,   7'd0,   32'sd0);
        queue_request(slm_pkg::REQ_READ,   7'd1,   32'sd0);
        queue_request(slm_pkg::REQ_INSERT, 7'd2,   32'sd12345);
        queue_request(slm_pkg::REQ_DELETE, 7'd1,   32'sd0);
        queue_request(slm_pkg::REQ_READ,   7'd1,   32'sd0);
        queue_request(slm_pkg::req_t'(3),  7'd127, slm_pkg::val_t'($urandom));
        queue_request(slm_pkg::REQ_READ,   7'd127, 32'sd0);

        // random phases with different idling profiles
        for (int phase = 0; phase < 4; phase++)
        begin
            wait_drained();
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            // fill to capacity first, then wander
            queue_segment(SEG_FILL, 170);
            queued = 170;
            while (queued < ITEMS_PHASE)
            begin
                int len;
                len = $urandom_range(80, 20);
                queue_segment(seg_kind_t'($urandom_range(2)), len);
                queued += len;
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (owed_responses.size() != 0)
        begin
            $display("%0d responses never arrived", owed_responses.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_req = pending_reqs.pop_front();
                req_ch.valid    <= 1'b1;
                req_ch.req_type <= next_req.req_type;
                req_ch.position <= next_req.position;
                req_ch.value    <= next_req.value;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Response ready: random stalls plus one long hold-off
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready   <= 1'b0;
            hold_left      <= 0;
            long_hold_done <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
        end
        else if (!long_hold_done && results_seen >= 60)
        begin
            long_hold_done <= 1'b1;
            hold_left      <= LONG_HOLD;
            rsp_ch.ready   <= 1'b0;
        end
        else
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Monitor: check responses, then predict newly accepted requests
    // ------------------------------------------------------------------------
    task automatic flag_error(string what, list_rsp_t want);
        fail_count++;
        if (fail_count <= 10)
            $display("%0s: expected status %0d value %0d, got status %0d value %0d",
                     what, want.status, want.read_value, rsp_ch.status,
                     rsp_ch.read_value);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            results_seen <= 0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (owed_responses.size() == 0)
                    flag_error("unexpected response", '0);
                else
                begin
                    list_rsp_t want;
                    want = owed_responses.pop_front();
                    if (rsp_ch.status !== want.status ||
                        rsp_ch.read_value !== want.read_value)
                        flag_error("response mismatch", want);
                end
                results_seen <= results_seen + 1;
            end
            if (req_ch.valid && req_ch.ready)
                owed_responses.push_back(apply_request('{req_type: req_ch.req_type,
                                                         position: req_ch.position,
                                                         value:    req_ch.value}));
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog on cycles without any accepted item
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout after %0d idle cycles", quiet_cycles);
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule

// ===== files.f =====
hdl/slm_pkg.sv
hdl/slm_req_if.sv
hdl/slm_rsp_if.sv
hdl/slm_store.sv
hdl/slm_ctrl.sv
hdl/static_linked_list_engine.sv
hdl/slm_checker.sv
tb/tb_top.sv
